// ===== sv/tgc_pkg.sv =====
// shared types, constants and register indexes for the touch gesture classifier
package tgc_pkg;

   localparam int COORD_BITS    = 12;
   localparam int TIME_BITS     = 32;
   localparam int MS_LIMIT_BITS = 16;
   localparam int GESTURE_BITS  = 3;
   localparam int GESTURE_COUNT = 6;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_MIN   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHORT_MIN  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GEST_EN    = 3'd4;

   localparam logic [MS_LIMIT_BITS-1:0] LONG_MIN_RESET  = 16'd1000;
   localparam logic [MS_LIMIT_BITS-1:0] SHORT_MIN_RESET = 16'd50;
   localparam logic [COORD_BITS-1:0]    X_LIMIT_RESET   = 12'd40;
   localparam logic [COORD_BITS-1:0]    Y_LIMIT_RESET   = 12'd40;
   localparam logic [GESTURE_COUNT-1:0] GEST_EN_RESET   = 6'h3F;

   typedef enum logic [GESTURE_BITS-1:0] {
      GEST_SHORT_CLICK = 3'd0,
      GEST_LONG_CLICK  = 3'd1,
      GEST_SWIPE_RIGHT = 3'd2,
      GEST_SWIPE_LEFT  = 3'd3,
      GEST_SWIPE_DOWN  = 3'd4,
      GEST_SWIPE_UP    = 3'd5
   } gesture_type;

   typedef struct packed {
      logic                  touched;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [TIME_BITS-1:0]  time_ms;
   } req_type;

   typedef struct packed {
      gesture_type           gesture;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } rsp_type;

   typedef struct packed {
      logic [MS_LIMIT_BITS-1:0] long_min;
      logic [MS_LIMIT_BITS-1:0] short_min;
      logic [COORD_BITS-1:0]    x_limit;
      logic [COORD_BITS-1:0]    y_limit;
      logic [GESTURE_COUNT-1:0] enable;
   } cfg_type;

   typedef struct packed {
      logic                  pen_is_down;
      logic [TIME_BITS-1:0]  down_time;
      logic [COORD_BITS-1:0] down_x;
      logic [COORD_BITS-1:0] down_y;
      logic [COORD_BITS-1:0] last_x;
      logic [COORD_BITS-1:0] last_y;
   } pen_type;

   typedef struct packed {
      logic        emit;
      gesture_type gesture;
   } cls_type;

endpackage

// ===== sv/touch_gesture_classifier.sv =====
// touch gesture classifier top level: input register, classify, result register
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data (touched, pos_x, pos_y, time_ms)
//   rsp      out        rsp_valid/rsp_ready    rsp_data (gesture, end_x, end_y)
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// one poll per cycle while no held result stalls the input; a taken poll passes
// through the input register, then classification into the result register
// polls that give no result still pass through the input register
// reset clears pen state, pipeline valids and loads the register defaults
// a held result stalls the input register, which stalls req_ready
module touch_gesture_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tgc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tgc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tgc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [tgc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tgc_pkg::*;

   cfg_type cfg;
   pen_type pen;
   cls_type cls;

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_item_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;
   logic    s1_fire;
   logic    rsp_load;
   logic    req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign rsp_load  = s1_fire && cls.emit;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff.gesture <= cls.gesture;
         rsp_data_ff.end_x   <= pen.last_x;
         rsp_data_ff.end_y   <= pen.last_y;
      end
   end

   tgc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tgc_state u_state (
      .clock (clock),
      .reset (reset),
      .step  (s1_fire),
      .item  (s1_item_ff),
      .pen   (pen)
   );

   tgc_classify u_classify (
      .item (s1_item_ff),
      .pen  (pen),
      .cfg  (cfg),
      .cls  (cls)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a touched poll never produces a result
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_item_ff.touched |-> !rsp_load)
      else $error("result produced by a touched item");

   // pen is down after a touched poll and up after a release
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_item_ff.touched |=> pen.pen_is_down)
      else $error("pen not down after touched item");

   assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_item_ff.touched |=> !pen.pen_is_down)
      else $error("pen still down after release item");

   // input back-pressure only when both registers are occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with a free register");

   // a new result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten");

endmodule

// ===== sv/tgc_cfg.sv =====
// configuration registers with the write port decode
module tgc_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [tgc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [tgc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output tgc_pkg::cfg_type                   cfg
);
   import tgc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LONG_MIN:  cfg_in.long_min  = csr_wdata[MS_LIMIT_BITS-1:0];
            CSR_SHORT_MIN: cfg_in.short_min = csr_wdata[MS_LIMIT_BITS-1:0];
            CSR_X_LIMIT:   cfg_in.x_limit   = csr_wdata[COORD_BITS-1:0];
            CSR_Y_LIMIT:   cfg_in.y_limit   = csr_wdata[COORD_BITS-1:0];
            CSR_GEST_EN:   cfg_in.enable    = csr_wdata[GESTURE_COUNT-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_min  <= LONG_MIN_RESET;
         cfg_ff.short_min <= SHORT_MIN_RESET;
         cfg_ff.x_limit   <= X_LIMIT_RESET;
         cfg_ff.y_limit   <= Y_LIMIT_RESET;
         cfg_ff.enable    <= GEST_EN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/tgc_state.sv =====
// pen-down and last-position tracking across polls
module tgc_state (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  tgc_pkg::req_type item,
   output tgc_pkg::pen_type pen
);
   import tgc_pkg::*;

   pen_type pen_ff;
   pen_type pen_in;

   always_comb begin
      pen_in = pen_ff;
      if (step) begin
         if (item.touched) begin
            if (!pen_ff.pen_is_down) begin
               pen_in.pen_is_down = 1'b1;
               pen_in.down_time   = item.time_ms;
               pen_in.down_x      = item.pos_x;
               pen_in.down_y      = item.pos_y;
            end
            pen_in.last_x = item.pos_x;
            pen_in.last_y = item.pos_y;
         end else begin
            pen_in.pen_is_down = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= '0;
      end else begin
         pen_ff <= pen_in;
      end
   end

   assign pen = pen_ff;

endmodule

// ===== sv/tgc_classify.sv =====
// release classification: hold time against minimums, travel against limits
module tgc_classify (
   input  tgc_pkg::req_type item,
   input  tgc_pkg::pen_type pen,
   input  tgc_pkg::cfg_type cfg,
   output tgc_pkg::cls_type cls
);
   import tgc_pkg::*;

   logic [TIME_BITS-1:0]  held;
   logic                  long_hit;
   logic                  short_hit;
   logic                  release_hit;
   logic [COORD_BITS:0]   right_reach;
   logic [COORD_BITS:0]   left_reach;
   logic [COORD_BITS:0]   down_reach;
   logic [COORD_BITS:0]   up_reach;
   logic                  go_right;
   logic                  go_left;
   logic                  go_down;
   logic                  go_up;
   gesture_type           code;

   // wrapping hold time; minimums are 16 bits so upper bits set means exceeded
   assign held      = item.time_ms - pen.down_time;
   assign long_hit  = (held[TIME_BITS-1:MS_LIMIT_BITS] != '0) ||
                      (held[MS_LIMIT_BITS-1:0] > cfg.long_min);
   assign short_hit = (held[TIME_BITS-1:MS_LIMIT_BITS] != '0) ||
                      (held[MS_LIMIT_BITS-1:0] > cfg.short_min);

   // signed travel compares rewritten as unsigned sums one bit wider
   assign right_reach = {1'b0, pen.down_x} + {1'b0, cfg.x_limit};
   assign left_reach  = {1'b0, pen.last_x} + {1'b0, cfg.x_limit};
   assign down_reach  = {1'b0, pen.down_y} + {1'b0, cfg.y_limit};
   assign up_reach    = {1'b0, pen.last_y} + {1'b0, cfg.y_limit};
   assign go_right    = {1'b0, pen.last_x} > right_reach;
   assign go_left     = {1'b0, pen.down_x} > left_reach;
   assign go_down     = {1'b0, pen.last_y} > down_reach;
   assign go_up       = {1'b0, pen.down_y} > up_reach;

   always_comb begin
      if (!long_hit) begin
         code = GEST_SHORT_CLICK;
      end else if (go_right) begin
         code = GEST_SWIPE_RIGHT;
      end else if (go_left) begin
         code = GEST_SWIPE_LEFT;
      end else if (go_down) begin
         code = GEST_SWIPE_DOWN;
      end else if (go_up) begin
         code = GEST_SWIPE_UP;
      end else begin
         code = GEST_LONG_CLICK;
      end
   end

   // a long hold emits, if its gesture is enabled, even when the short minimum is set higher
   assign release_hit = !item.touched && pen.pen_is_down;
   assign cls.gesture = code;
   assign cls.emit    = release_hit && (long_hit || short_hit) && cfg.enable[code];

endmodule
